// ===== design/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg: shared definitions for the signed decimal formatter
// Character codes, digit sizing and the control bundle that passes
// between the sequencer and the character emitter.
// ----------------------------------------------------------------------------
package sdf_pkg;

    // Default width of the signed value
    localparam int VALUE_BITS_DEF = 64;

    // Decimal digit storage: 20 digits cover any 64-bit magnitude
    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);

    // Binary bits folded into the digit register per conversion step
    localparam int BITS_PER_STEP = 4;

    // ASCII codes
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    // Sequencer to emitter control
    typedef struct packed {
        logic load;   // take the converted digits
        logic neg;    // prefix a minus sign
    } t_emit_ctl;

endpackage

// ===== design/sdf_dabble.sv =====
// ----------------------------------------------------------------------------
// sdf_dabble: iterative binary to BCD converter
// Shift-and-add-3 unit reused every cycle; folds BITS_PER_STEP magnitude
// bits into a 20-digit BCD register per cycle until all bits are consumed.
// ----------------------------------------------------------------------------
module sdf_dabble
    import sdf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_mag,
    output logic                  o_busy,
    output logic [BCD_W-1:0]      o_bcd
);

    localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W = STEPS * BITS_PER_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PAD_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;

    // Add 3 to every digit of 5 or more
    function automatic logic [BCD_W-1:0] f_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                res[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return res;
    endfunction

    // One step: BITS_PER_STEP adjust-and-shift passes
    always_comb begin
        logic [BCD_W-1:0] bcd;
        logic [PAD_W-1:0] bin;
        bcd    = r_bcd;
        bin    = r_bin;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(STEPS);
            bin    = PAD_W'(i_mag);
            bcd    = '0;
        end else if (r_busy) begin
            for (int k = 0; k < BITS_PER_STEP; k++) begin
                bcd = f_adjust(bcd);
                bcd = {bcd[BCD_W-2:0], bin[PAD_W-1]};
                bin = {bin[PAD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
        n_bin = bin;
        n_bcd = bcd;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_busy = r_busy;
    assign o_bcd  = r_bcd;

endmodule

// ===== design/sdf_emit.sv =====
// ----------------------------------------------------------------------------
// sdf_emit: character emitter with output register
// Drops leading zero digits on load, then sends an optional minus sign
// and the digits most significant first, one beat per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module sdf_emit
    import sdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_emit_ctl        i_ctl,
    input  logic [BCD_W-1:0] i_bcd,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_character,
    output logic             o_last
);

    logic              r_busy, n_busy;
    logic              r_sign, n_sign;
    logic [DCNT_W-1:0] r_left, n_left;
    logic [BCD_W-1:0]  r_digits, n_digits;
    logic              r_valid, n_valid;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;

    logic [DCNT_W-1:0] w_ndig;
    logic [DCNT_W-1:0] w_zeros;
    logic [BCD_W-1:0]  w_aligned;
    logic              w_adv;

    // Significant digit count (at least one) and left alignment
    always_comb begin
        w_ndig = DCNT_W'(1);
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (i_bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                w_ndig = DCNT_W'(d + 1);
            end
        end
        w_zeros   = DCNT_W'(MAX_DIGITS) - w_ndig;
        w_aligned = i_bcd << {w_zeros, 2'b00};
    end

    assign w_adv = !r_valid || i_ready;

    // Next character and output register
    always_comb begin
        n_busy   = r_busy;
        n_sign   = r_sign;
        n_left   = r_left;
        n_digits = r_digits;
        n_valid  = r_valid;
        n_char   = r_char;
        n_last   = r_last;
        if (w_adv) begin
            n_valid = r_busy;
            if (r_busy) begin
                if (r_sign) begin
                    n_char = CHAR_MINUS;
                    n_last = 1'b0;
                    n_sign = 1'b0;
                end else begin
                    n_char   = CHAR_ZERO + {4'b0000, r_digits[BCD_W-1 -: DIGIT_W]};
                    n_last   = (r_left == DCNT_W'(1));
                    n_digits = {r_digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_left   = r_left - 1'b1;
                    if (r_left == DCNT_W'(1)) begin
                        n_busy = 1'b0;
                    end
                end
            end
        end
        if (i_ctl.load) begin
            n_busy   = 1'b1;
            n_sign   = i_ctl.neg;
            n_digits = w_aligned;
            n_left   = w_ndig;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_sign  <= 1'b0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_sign  <= n_sign;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_free      = !r_busy;
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

// ===== design/signed_decimal_formatter_top.sv =====
// Flow: the BCD unit converts in 4-bit steps; characters leave one per cycle
//   while the receiver is ready, overlapping the next item's conversion.
// Reset: synchronous, active low; clears the control state of sequencer, converter and emitter.
// ----------------------------------------------------------------------------
// signed_decimal_formatter_top: signed integer to decimal ASCII text
// Takes the magnitude of a signed value, converts it to BCD in a shared
// shift-and-add-3 unit and sends the text one character per beat.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_top
    import sdf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_character,
    output logic        o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic                  r_neg, n_neg;

    logic [VALUE_BITS-1:0] w_raw;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_sign;
    logic                  w_accept;
    logic                  w_dab_busy;
    logic [BCD_W-1:0]      w_bcd;
    logic                  w_emit_free;
    t_emit_ctl             w_ctl;

    // Magnitude; the most negative value maps to 2^(VALUE_BITS-1) unsigned
    assign w_raw    = i_value[VALUE_BITS-1:0];
    assign w_sign   = w_raw[VALUE_BITS-1];
    assign w_mag    = w_sign ? (~w_raw + 1'b1) : w_raw;
    assign w_accept = i_valid && o_ready;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        w_ctl     = '0;
        w_ctl.neg = r_neg;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = w_sign;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (!w_dab_busy) begin
                    if (w_emit_free) begin
                        w_ctl.load = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (w_emit_free) begin
                    w_ctl.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    sdf_dabble #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_mag),
        .o_busy  (w_dab_busy),
        .o_bcd   (w_bcd)
    );

    sdf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_bcd       (w_bcd),
        .o_free      (w_emit_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

    // Converter starts on every accepted beat
    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_dab_busy && r_state == S_CONV))
        else $error("converter not started after accept");

    // Digits are handed over only to an idle emitter, after conversion
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |-> (w_emit_free && !w_dab_busy))
        else $error("emitter loaded while busy");

    // A minus sign never ends the text
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == CHAR_MINUS) |-> !o_last)
        else $error("minus sign flagged as last");

endmodule
